>>> hw/rtl/tpsq_pkg.sv
package tpsq_pkg;

  // pool geometry
  localparam int PoolSize = 512;
  localparam int AddrW    = $clog2(PoolSize);
  localparam int StepW    = $clog2(PoolSize + 1);

  // request and result field widths
  localparam int OpW    = 2;
  localparam int IdxW   = 9;
  localparam int TimeW  = 32;
  localparam int DestW  = 8;
  localparam int TagW   = 32;

  localparam logic [TimeW-1:0] AllOnes = '1;

  localparam logic FlagUnused = 1'b0;
  localparam logic FlagUsed   = 1'b1;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef enum logic [OpW-1:0] {
    OpAlloc   = 2'd0,
    OpFree    = 2'd1,
    OpSetData = 2'd2,
    OpSetTime = 2'd3
  } tpsq_op_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_step;
    logic start;
    logic alloc_chk;
    logic walk_chk;
    logic link_prev;
    logic link_self;
    logic load_out;
  } tpsq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic op_alloc;
    logic op_settime;
    logic flag_free;
    logic walk_go;
    logic has_prev;
    logic out_free;
  } tpsq_stat_t;

endpackage

>>> hw/rtl/tpsq_ram.sv
module tpsq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/tpsq_datapath.sv
module tpsq_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tpsq_pkg::tpsq_cmd_t             cmd_i,
  output tpsq_pkg::tpsq_stat_t            stat_o,
  input  logic [tpsq_pkg::OpW-1:0]        operation_i,
  input  logic [tpsq_pkg::IdxW-1:0]       timer_index_i,
  input  logic [tpsq_pkg::TimeW-1:0]      timeout_ticks_i,
  input  logic [tpsq_pkg::TimeW-1:0]      now_count_i,
  input  logic [tpsq_pkg::DestW-1:0]      destination_id_i,
  input  logic [tpsq_pkg::TagW-1:0]       tag_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            status_o,
  output logic [tpsq_pkg::IdxW-1:0]       result_index_o,
  output logic [tpsq_pkg::IdxW-1:0]       head_index_o,
  output logic [tpsq_pkg::TimeW-1:0]      earliest_deadline_o
);

  // captured request
  logic [tpsq_pkg::OpW-1:0]   op_q;
  logic [tpsq_pkg::IdxW-1:0]  idx_q;
  logic [tpsq_pkg::TimeW-1:0] dl_q;
  logic [tpsq_pkg::DestW-1:0] dest_q;
  logic [tpsq_pkg::TagW-1:0]  tag_q;

  // scan, walk and list state
  logic [tpsq_pkg::AddrW-1:0] scan_q;
  logic [tpsq_pkg::AddrW-1:0] cur_q;
  logic [tpsq_pkg::AddrW-1:0] prev_q;
  logic                       has_prev_q;
  logic [tpsq_pkg::StepW-1:0] steps_q;
  logic [tpsq_pkg::AddrW-1:0] head_q;
  logic [tpsq_pkg::TimeW-1:0] head_dl_q;
  logic                       status_q;
  logic [tpsq_pkg::AddrW-1:0] granted_q;

  // result register
  logic                       out_valid_q;
  logic                       out_status_q;
  logic [tpsq_pkg::IdxW-1:0]  out_result_q;
  logic [tpsq_pkg::IdxW-1:0]  out_head_q;
  logic [tpsq_pkg::TimeW-1:0] out_dl_q;

  logic                       addressable;
  logic [tpsq_pkg::AddrW-1:0] idx_a;

  logic                       flag_we;
  logic [tpsq_pkg::AddrW-1:0] flag_waddr;
  logic                       flag_wdata;
  logic                       flag_rdata;

  logic                       dl_we;
  logic [tpsq_pkg::TimeW-1:0] dl_rdata;
  logic [tpsq_pkg::TimeW-1:0] dl_cur;

  logic                       link_we;
  logic [tpsq_pkg::AddrW-1:0] link_waddr;
  logic [tpsq_pkg::AddrW-1:0] link_wdata;
  logic [tpsq_pkg::AddrW-1:0] link_rdata;

  logic                       tag_we;
  logic                       walk_go;

  assign idx_a       = tpsq_pkg::AddrW'(idx_q);
  assign addressable = (idx_q != '0) &&
                       ({1'b0, idx_q} < (tpsq_pkg::IdxW + 1)'(tpsq_pkg::PoolSize));

  // sentinel entry always reads as the latest possible deadline
  assign dl_cur  = (cur_q == '0) ? tpsq_pkg::AllOnes : dl_rdata;
  assign walk_go = (dl_q > dl_cur) && (steps_q < tpsq_pkg::StepW'(tpsq_pkg::PoolSize));

  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = scan_q;
    flag_wdata = tpsq_pkg::FlagUnused;
    if (cmd_i.clear_step) begin
      flag_we    = 1'b1;
      flag_wdata = (scan_q == '0) ? tpsq_pkg::FlagUsed : tpsq_pkg::FlagUnused;
    end else if (cmd_i.start && addressable && (op_q == tpsq_pkg::OpFree)) begin
      flag_we    = 1'b1;
      flag_waddr = idx_a;
    end else if (cmd_i.start && addressable && (op_q == tpsq_pkg::OpSetTime)) begin
      flag_we    = 1'b1;
      flag_waddr = idx_a;
      flag_wdata = tpsq_pkg::FlagUsed;
    end else if (cmd_i.alloc_chk && (flag_rdata == tpsq_pkg::FlagUnused)) begin
      flag_we    = 1'b1;
      flag_wdata = tpsq_pkg::FlagUsed;
    end
  end

  assign dl_we  = cmd_i.start && addressable && (op_q == tpsq_pkg::OpSetTime);
  assign tag_we = cmd_i.start && addressable && (op_q == tpsq_pkg::OpSetData);

  always_comb begin
    link_we    = cmd_i.link_prev || cmd_i.link_self;
    link_waddr = idx_a;
    link_wdata = cur_q;
    if (cmd_i.link_prev) begin
      link_waddr = prev_q;
      link_wdata = idx_a;
    end
  end

  tpsq_ram #(.Width(1), .Depth(tpsq_pkg::PoolSize)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (scan_q),
    .rdata_o (flag_rdata)
  );

  tpsq_ram #(.Width(tpsq_pkg::TimeW), .Depth(tpsq_pkg::PoolSize)) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (idx_a),
    .wdata_i (dl_q),
    .raddr_i (cur_q),
    .rdata_o (dl_rdata)
  );

  tpsq_ram #(.Width(tpsq_pkg::AddrW), .Depth(tpsq_pkg::PoolSize)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (cur_q),
    .rdata_o (link_rdata)
  );

  // destination and tag are held per entry
  tpsq_ram #(.Width(tpsq_pkg::DestW + tpsq_pkg::TagW), .Depth(tpsq_pkg::PoolSize)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (idx_a),
    .wdata_i ({dest_q, tag_q}),
    .raddr_i (idx_a),
    .rdata_o ()
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      idx_q  <= timer_index_i;
      dl_q   <= timeout_ticks_i + now_count_i;
      dest_q <= destination_id_i;
      tag_q  <= tag_data_i;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_result_q <= tpsq_pkg::IdxW'(granted_q);
      out_head_q   <= tpsq_pkg::IdxW'(head_q);
      out_dl_q     <= head_dl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      has_prev_q  <= 1'b0;
      steps_q     <= '0;
      head_q      <= '0;
      head_dl_q   <= tpsq_pkg::AllOnes;
      status_q    <= tpsq_pkg::StatusOk;
      granted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.start) begin
        status_q   <= tpsq_pkg::StatusOk;
        granted_q  <= '0;
        scan_q     <= '0;
        cur_q      <= head_q;
        prev_q     <= '0;
        has_prev_q <= 1'b0;
        steps_q    <= '0;
      end
      if (cmd_i.alloc_chk) begin
        if (flag_rdata == tpsq_pkg::FlagUnused) begin
          granted_q <= scan_q;
        end else if (stat_o.scan_last) begin
          status_q <= tpsq_pkg::StatusFull;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (cmd_i.walk_chk && walk_go) begin
        prev_q     <= cur_q;
        has_prev_q <= 1'b1;
        cur_q      <= link_rdata;
        steps_q    <= steps_q + 1'b1;
      end
      if (cmd_i.link_self && !has_prev_q) begin
        head_q    <= idx_a;
        head_dl_q <= dl_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.scan_last  = (scan_q == tpsq_pkg::AddrW'(tpsq_pkg::PoolSize - 1));
    stat_o.op_alloc   = (op_q == tpsq_pkg::OpAlloc);
    stat_o.op_settime = (op_q == tpsq_pkg::OpSetTime) && addressable;
    stat_o.flag_free  = (flag_rdata == tpsq_pkg::FlagUnused);
    stat_o.walk_go    = walk_go;
    stat_o.has_prev   = has_prev_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign result_index_o      = out_result_q;
  assign head_index_o        = out_head_q;
  assign earliest_deadline_o = out_dl_q;

endmodule

>>> hw/rtl/tpsq_ctrl.sv
module tpsq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpsq_pkg::tpsq_stat_t stat_i,
  output tpsq_pkg::tpsq_cmd_t  cmd_o
);

  localparam logic [3:0] StClear     = 4'd0;
  localparam logic [3:0] StIdle      = 4'd1;
  localparam logic [3:0] StDecode    = 4'd2;
  localparam logic [3:0] StAllocRd   = 4'd3;
  localparam logic [3:0] StAllocChk  = 4'd4;
  localparam logic [3:0] StWalkRd    = 4'd5;
  localparam logic [3:0] StWalkCmp   = 4'd6;
  localparam logic [3:0] StLinkPrev  = 4'd7;
  localparam logic [3:0] StLinkSelf  = 4'd8;
  localparam logic [3:0] StDone      = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        cmd_o.start = 1'b1;
        if (stat_i.op_alloc) begin
          state_d = StAllocRd;
        end else if (stat_i.op_settime) begin
          state_d = StWalkRd;
        end else begin
          state_d = StDone;
        end
      end
      StAllocRd: begin
        state_d = StAllocChk;
      end
      StAllocChk: begin
        cmd_o.alloc_chk = 1'b1;
        if (stat_i.flag_free || stat_i.scan_last) begin
          state_d = StDone;
        end else begin
          state_d = StAllocRd;
        end
      end
      StWalkRd: begin
        state_d = StWalkCmp;
      end
      StWalkCmp: begin
        cmd_o.walk_chk = 1'b1;
        if (stat_i.walk_go) begin
          state_d = StWalkRd;
        end else if (stat_i.has_prev) begin
          state_d = StLinkPrev;
        end else begin
          state_d = StLinkSelf;
        end
      end
      StLinkPrev: begin
        cmd_o.link_prev = 1'b1;
        state_d         = StLinkSelf;
      end
      StLinkSelf: begin
        cmd_o.link_self = 1'b1;
        state_d         = StDone;
      end
      StDone: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/timer_pool_sorted_queue_top.sv
// Sorted timer queue over a fixed pool of entries.
// Request channel (in_valid_i / in_ready_o): operation, timer index, timeout,
// current tick count, destination and tag. One request is worked on at a time.
// Result channel (out_valid_o / out_ready_i): status, granted index, list head
// and earliest deadline after the request; exactly one result per request.
// From the accepting edge to a valid result, each request passes a decode
// state and ends in a done state that loads the result register once free;
// free, set-data and ignored requests pass nothing in between, allocate a
// read and a check state per entry scanned (at most PoolSize entries), and
// set-time a read of the deadline and link memories and a compare per entry
// walked, then link-prev when the entry lands behind the head, and link-self.
// The memories have one write and one registered read port, which is why the
// free-entry scan and the list walk each spend a read state on every entry.
// A new request is taken once the previous one has moved into the result
// register, so a stalled receiver holds the block only when a second result
// is ready before the first is taken.
// After reset the block sweeps the usage flags, one entry per cycle
// (PoolSize entries, 512 here), with in_ready_o low; the list is left holding
// only the sentinel entry with an all-ones deadline.
module timer_pool_sorted_queue_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tpsq_pkg::OpW-1:0]   operation_i,
  input  logic [tpsq_pkg::IdxW-1:0]  timer_index_i,
  input  logic [tpsq_pkg::TimeW-1:0] timeout_ticks_i,
  input  logic [tpsq_pkg::TimeW-1:0] now_count_i,
  input  logic [tpsq_pkg::DestW-1:0] destination_id_i,
  input  logic [tpsq_pkg::TagW-1:0]  tag_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       status_o,
  output logic [tpsq_pkg::IdxW-1:0]  result_index_o,
  output logic [tpsq_pkg::IdxW-1:0]  head_index_o,
  output logic [tpsq_pkg::TimeW-1:0] earliest_deadline_o
);

  tpsq_pkg::tpsq_cmd_t  cmd;
  tpsq_pkg::tpsq_stat_t stat;

  tpsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tpsq_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .operation_i         (operation_i),
    .timer_index_i       (timer_index_i),
    .timeout_ticks_i     (timeout_ticks_i),
    .now_count_i         (now_count_i),
    .destination_id_i    (destination_id_i),
    .tag_data_i          (tag_data_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .status_o            (status_o),
    .result_index_o      (result_index_o),
    .head_index_o        (head_index_o),
    .earliest_deadline_o (earliest_deadline_o)
  );

endmodule

>>> hw/rtl/tpsq_checker.sv
module tpsq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       status_o,
  input logic [tpsq_pkg::IdxW-1:0]  result_index_o,
  input logic [tpsq_pkg::IdxW-1:0]  head_index_o,
  input logic [tpsq_pkg::TimeW-1:0] earliest_deadline_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_index_o) &&
    $stable(status_o) && $stable(head_index_o) && $stable(earliest_deadline_o))
    else $error("stalled result changed");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // a full pool grants nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tpsq_pkg::StatusFull) |-> result_index_o == '0)
    else $error("index granted with pool full");

  // the sentinel heads the list only with its all-ones deadline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (head_index_o == '0) |-> earliest_deadline_o == tpsq_pkg::AllOnes)
    else $error("sentinel at head without all-ones deadline");

endmodule

bind timer_pool_sorted_queue_top tpsq_checker u_checker (.*);
